@@ rtl/ufbs_pkg.sv @@
package ufbs_pkg;

  localparam int BAUD_W     = 24;
  localparam int CORE_W     = 28;
  localparam int PCT_W      = 7;
  localparam int REFCLK_W   = 22;
  localparam int PROD_W     = 26;
  localparam int DVD_W      = 31;
  localparam int DV_W       = 23;
  localparam int ERR_W      = 17;
  localparam int DIV_OUT_W  = 16;
  localparam int FRAC_W     = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CNT_W      = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_CORE_CLK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACCEPT_PCT = 2'd1;

  localparam logic [CORE_W-1:0] CORE_CLK_RST   = 28'd100000000;
  localparam logic [PCT_W-1:0]  ACCEPT_PCT_RST = 7'd3;
  localparam logic [ERR_W-1:0]  NO_ERR_BOUND   = 17'd100000;
  localparam logic [DV_W-1:0]   DV_MIN         = 23'd3;
  localparam logic [DV_W-1:0]   DV_MAX         = 23'd65535;
  localparam logic [BAUD_W-1:0] PCT_SCALE      = 24'd100;

  typedef enum logic [1:0] {
    SEL_SCALE,
    SEL_DVQ,
    SEL_GOT
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     cap_scaled;
    logic     cap_dv;
    logic     eval;
    logic     step;
    logic     cap_accept;
    logic     out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
    logic baud_zero;
    logic dv_ok;
    logic pair_last;
    logic found_zero;
    logic out_free;
  } dp_stat_t;

endpackage

@@ rtl/ufbs_div.sv @@
module ufbs_div (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic [ufbs_pkg::DVD_W-1:0]      dividend,
  input  logic [ufbs_pkg::BAUD_W-1:0]     divisor,
  output logic                            done,
  output logic [ufbs_pkg::DVD_W-1:0]      quotient,
  output logic [ufbs_pkg::BAUD_W-1:0]     remainder
);

  logic [ufbs_pkg::DVD_W-1:0]  quo_r;
  logic [ufbs_pkg::BAUD_W-1:0] rem_r;
  logic [ufbs_pkg::BAUD_W-1:0] dsr_r;
  logic [ufbs_pkg::CNT_W-1:0]  cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic [ufbs_pkg::BAUD_W:0]   rem_sh;
  logic [ufbs_pkg::BAUD_W:0]   rem_sub;
  logic                        fits;

  assign rem_sh  = {rem_r, quo_r[ufbs_pkg::DVD_W-1]};
  assign fits    = rem_sh >= {1'b0, dsr_r};
  assign rem_sub = rem_sh - {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= ufbs_pkg::CNT_W'(ufbs_pkg::DVD_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ufbs_pkg::CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[ufbs_pkg::DVD_W-2:0], fits};
      rem_r <= fits ? rem_sub[ufbs_pkg::BAUD_W-1:0] : rem_sh[ufbs_pkg::BAUD_W-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ rtl/ufbs_datapath.sv @@
module ufbs_datapath #(
  parameter int MAX_FRAC = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ufbs_pkg::ctrl_cmd_t                cmd,
  output ufbs_pkg::dp_stat_t                 stat,
  input  logic [ufbs_pkg::BAUD_W-1:0]        in_target_baud,
  input  logic                               cfg_valid,
  input  logic [ufbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ufbs_pkg::CORE_W-1:0]        cfg_data,
  input  logic                               out_stall,
  output logic                               out_valid,
  output logic                               out_accepted,
  output logic [ufbs_pkg::DIV_OUT_W-1:0]     out_divisor,
  output logic [ufbs_pkg::FRAC_W-1:0]        out_mul_val,
  output logic [ufbs_pkg::FRAC_W-1:0]        out_add_val,
  output logic [ufbs_pkg::ERR_W-1:0]         out_best_error
);

  localparam logic [ufbs_pkg::FRAC_W-1:0] FRAC_LAST = ufbs_pkg::FRAC_W'(MAX_FRAC);

  logic [ufbs_pkg::CORE_W-1:0]    core_clk_r;
  logic [ufbs_pkg::PCT_W-1:0]     pct_r;
  logic [ufbs_pkg::BAUD_W-1:0]    baud_r;
  logic [ufbs_pkg::FRAC_W-1:0]    m_r;
  logic [ufbs_pkg::FRAC_W-1:0]    a_r;
  logic [ufbs_pkg::REFCLK_W-1:0]  scaled_r;
  logic [ufbs_pkg::DV_W-1:0]      dv_r;
  logic [ufbs_pkg::ERR_W-1:0]     best_err_r;
  logic [ufbs_pkg::DIV_OUT_W-1:0] best_div_r;
  logic [ufbs_pkg::FRAC_W-1:0]    best_mul_r;
  logic [ufbs_pkg::FRAC_W-1:0]    best_add_r;
  logic                           found_zero_r;
  logic                           accept_r;
  logic                           out_valid_r;
  logic                           out_accepted_r;
  logic [ufbs_pkg::DIV_OUT_W-1:0] out_divisor_r;
  logic [ufbs_pkg::FRAC_W-1:0]    out_mul_val_r;
  logic [ufbs_pkg::FRAC_W-1:0]    out_add_val_r;
  logic [ufbs_pkg::ERR_W-1:0]     out_best_error_r;

  logic [ufbs_pkg::REFCLK_W-1:0]  refclk;
  logic [ufbs_pkg::PROD_W-1:0]    prod;
  logic [ufbs_pkg::CNT_W-1:0]     msum;
  logic [ufbs_pkg::DVD_W-1:0]     lim_prod;
  logic [ufbs_pkg::DVD_W-1:0]     err_scaled;
  logic [ufbs_pkg::DVD_W-1:0]     dvd;
  logic [ufbs_pkg::BAUD_W-1:0]    dsr;
  logic                           div_done;
  logic [ufbs_pkg::DVD_W-1:0]     div_quo;
  logic [ufbs_pkg::BAUD_W-1:0]    div_rem;
  logic                           round_up;
  logic [ufbs_pkg::BAUD_W-1:0]    got;
  logic [ufbs_pkg::BAUD_W-1:0]    err;

  assign refclk   = core_clk_r[ufbs_pkg::CORE_W-1:6];
  assign prod     = ufbs_pkg::PROD_W'(m_r) * ufbs_pkg::PROD_W'(refclk);
  assign msum     = ufbs_pkg::CNT_W'(m_r) + ufbs_pkg::CNT_W'(a_r);
  assign lim_prod = ufbs_pkg::DVD_W'(baud_r) * ufbs_pkg::DVD_W'(pct_r);
  // err < floor(baud*pct/100) is the same as (err+1)*100 <= baud*pct
  assign err_scaled = (ufbs_pkg::DVD_W'(best_err_r) + ufbs_pkg::DVD_W'(1)) *
                      ufbs_pkg::DVD_W'(ufbs_pkg::PCT_SCALE);

  always_comb begin
    case (cmd.div_sel)
      ufbs_pkg::SEL_SCALE: begin
        dvd = ufbs_pkg::DVD_W'(prod);
        dsr = ufbs_pkg::BAUD_W'(msum);
      end
      ufbs_pkg::SEL_DVQ: begin
        dvd = ufbs_pkg::DVD_W'(scaled_r);
        dsr = baud_r;
      end
      ufbs_pkg::SEL_GOT: begin
        dvd = ufbs_pkg::DVD_W'(scaled_r);
        dsr = ufbs_pkg::BAUD_W'(dv_r[ufbs_pkg::DIV_OUT_W-1:0]);
      end
      default: begin
        dvd = ufbs_pkg::DVD_W'(prod);
        dsr = ufbs_pkg::BAUD_W'(msum);
      end
    endcase
  end

  ufbs_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_start),
    .dividend  (dvd),
    .divisor   (dsr),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  assign round_up = div_rem > (baud_r >> 1);
  assign got      = ufbs_pkg::BAUD_W'(div_quo[ufbs_pkg::REFCLK_W-1:0]);
  assign err      = (got <= baud_r) ? (baud_r - got) : (got - baud_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      core_clk_r  <= ufbs_pkg::CORE_CLK_RST;
      pct_r       <= ufbs_pkg::ACCEPT_PCT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_index == ufbs_pkg::CFG_CORE_CLK) begin
        core_clk_r <= cfg_data;
      end
      if (cfg_valid && cfg_index == ufbs_pkg::CFG_ACCEPT_PCT) begin
        pct_r <= cfg_data[ufbs_pkg::PCT_W-1:0];
      end
      if (cmd.out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      baud_r       <= in_target_baud;
      m_r          <= ufbs_pkg::FRAC_W'(1);
      a_r          <= '0;
      best_err_r   <= ufbs_pkg::NO_ERR_BOUND;
      best_div_r   <= '0;
      best_mul_r   <= ufbs_pkg::FRAC_W'(1);
      best_add_r   <= '0;
      found_zero_r <= 1'b0;
    end
    if (cmd.cap_scaled) begin
      scaled_r <= div_quo[ufbs_pkg::REFCLK_W-1:0];
    end
    if (cmd.cap_dv) begin
      dv_r <= ufbs_pkg::DV_W'(div_quo[ufbs_pkg::REFCLK_W-1:0]) + ufbs_pkg::DV_W'(round_up);
    end
    if (cmd.eval && err < ufbs_pkg::BAUD_W'(best_err_r)) begin
      best_err_r   <= err[ufbs_pkg::ERR_W-1:0];
      best_div_r   <= dv_r[ufbs_pkg::DIV_OUT_W-1:0];
      best_mul_r   <= m_r;
      best_add_r   <= a_r;
      found_zero_r <= err == '0;
    end
    if (cmd.step) begin
      if (a_r == FRAC_LAST) begin
        a_r <= '0;
        m_r <= m_r + 1'b1;
      end else begin
        a_r <= a_r + 1'b1;
      end
    end
    if (cmd.cap_accept) begin
      accept_r <= err_scaled <= lim_prod;
    end
    if (cmd.out_load) begin
      out_accepted_r   <= accept_r;
      out_divisor_r    <= best_div_r;
      out_mul_val_r    <= best_mul_r;
      out_add_val_r    <= best_add_r;
      out_best_error_r <= best_err_r;
    end
  end

  assign stat.div_done   = div_done;
  assign stat.baud_zero  = baud_r == '0;
  assign stat.dv_ok      = dv_r >= ufbs_pkg::DV_MIN && dv_r <= ufbs_pkg::DV_MAX;
  assign stat.pair_last  = m_r == FRAC_LAST && a_r == FRAC_LAST;
  assign stat.found_zero = found_zero_r;
  assign stat.out_free   = !out_valid_r || !out_stall;

  assign out_valid      = out_valid_r;
  assign out_accepted   = out_accepted_r;
  assign out_divisor    = out_divisor_r;
  assign out_mul_val    = out_mul_val_r;
  assign out_add_val    = out_add_val_r;
  assign out_best_error = out_best_error_r;

`ifndef SYNTHESIS
  // a chosen divisor is never below the minimum; fallback pairs with the bound error
  a_fallback: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_divisor_r == '0) == (out_best_error_r == ufbs_pkg::NO_ERR_BOUND)))
    else $error("divisor and error fallback disagree");
  a_div_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_divisor_r != '0 |-> out_divisor_r >= ufbs_pkg::DIV_OUT_W'(3))
    else $error("divisor below minimum");
  a_mul_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_mul_val_r != '0 && out_mul_val_r <= FRAC_LAST)
    else $error("multiplier out of range");
  a_err_update: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.eval && !cmd.load |=> best_err_r <= $past(best_err_r))
    else $error("best error grew");
`endif

endmodule

@@ rtl/ufbs_ctrl.sv @@
module ufbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ufbs_pkg::dp_stat_t  stat,
  output ufbs_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_SCALE,
    ST_WAIT_SCALE,
    ST_DVQ,
    ST_WAIT_DVQ,
    ST_RANGE,
    ST_WAIT_GOT,
    ST_NEXT,
    ST_LIMIT,
    ST_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.div_sel = ufbs_pkg::SEL_SCALE;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.baud_zero ? ST_LIMIT : ST_SCALE;
      end
      ST_SCALE: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ufbs_pkg::SEL_SCALE;
        state_nxt     = ST_WAIT_SCALE;
      end
      ST_WAIT_SCALE: begin
        if (stat.div_done) begin
          cmd.cap_scaled = 1'b1;
          state_nxt      = ST_DVQ;
        end
      end
      ST_DVQ: begin
        cmd.div_start = 1'b1;
        cmd.div_sel   = ufbs_pkg::SEL_DVQ;
        state_nxt     = ST_WAIT_DVQ;
      end
      ST_WAIT_DVQ: begin
        if (stat.div_done) begin
          cmd.cap_dv = 1'b1;
          state_nxt  = ST_RANGE;
        end
      end
      ST_RANGE: begin
        if (stat.dv_ok) begin
          cmd.div_start = 1'b1;
          cmd.div_sel   = ufbs_pkg::SEL_GOT;
          state_nxt     = ST_WAIT_GOT;
        end else begin
          state_nxt = ST_NEXT;
        end
      end
      ST_WAIT_GOT: begin
        cmd.div_sel = ufbs_pkg::SEL_GOT;
        if (stat.div_done) begin
          cmd.eval  = 1'b1;
          state_nxt = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (stat.found_zero || stat.pair_last) begin
          state_nxt = ST_LIMIT;
        end else begin
          cmd.step  = 1'b1;
          state_nxt = ST_SCALE;
        end
      end
      ST_LIMIT: begin
        cmd.cap_accept = 1'b1;
        state_nxt      = ST_FINISH;
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = state_r != ST_IDLE;

endmodule

@@ rtl/uart_fractional_baud_search_top.sv @@
// UART fractional baud divider search.
// Input channel: in_target_baud with in_valid/in_stall; a transfer happens when
// in_valid is high and in_stall is low. One item is worked on at a time; the
// block takes a new item as soon as the previous search has moved its result
// into the output register, even if that result is still waiting.
// Result channel: out_valid/out_stall with accepted, divisor, mul_val, add_val
// and best_error; one result per item, held stable while out_stall is high.
// Configuration: cfg_valid/cfg_ready (ready is always high), cfg_index 0 is
// core_clock_hz, 1 is accept_error_pct; other indexes are ignored. Write only
// while the block is idle.
// Each pair (mul, add) uses up to three passes of the shared bit-serial
// divider (two when the divisor is out of range). A full sweep covers
// MAX_FRAC*(MAX_FRAC+1) pairs; a zero target skips the sweep, and a
// zero-error pair ends the search early.
// Reset (rst_n, synchronous, active low) clears the controller, the output
// valid and returns both registers to their default values.
module uart_fractional_baud_search_top #(
  parameter int MAX_FRAC = 15
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ufbs_pkg::BAUD_W-1:0]        in_target_baud,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic                               out_accepted,
  output logic [ufbs_pkg::DIV_OUT_W-1:0]     out_divisor,
  output logic [ufbs_pkg::FRAC_W-1:0]        out_mul_val,
  output logic [ufbs_pkg::FRAC_W-1:0]        out_add_val,
  output logic [ufbs_pkg::ERR_W-1:0]         out_best_error,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ufbs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ufbs_pkg::CORE_W-1:0]        cfg_data
);

  ufbs_pkg::ctrl_cmd_t cmd;
  ufbs_pkg::dp_stat_t  stat;

  assign cfg_ready = 1'b1;

  ufbs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ufbs_datapath #(
    .MAX_FRAC (MAX_FRAC)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_target_baud (in_target_baud),
    .cfg_valid      (cfg_valid),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .out_accepted   (out_accepted),
    .out_divisor    (out_divisor),
    .out_mul_val    (out_mul_val),
    .out_add_val    (out_add_val),
    .out_best_error (out_best_error)
  );

endmodule
